// File: hdl/swr_pkg.sv
// Package: shared constants, codes and interface structs of the sequence receive window.
package swr_pkg;

  localparam int WINDOW    = 64;
  localparam int SLOT_W    = $clog2(WINDOW);
  localparam int DIST_W    = $clog2(WINDOW + 1);
  localparam int SEQ_W     = 64;
  localparam int ID_W      = 64;
  localparam int MAXGAP_W  = 7;
  localparam int STATUS_W  = 3;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 64;

  localparam logic [STATUS_W-1:0] ST_IN_ORDER     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OUT_OF_ORDER = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_STALE        = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MALFORMED    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_GAP          = 3'd5;
  localparam logic [STATUS_W-1:0] ST_SETTLED      = 3'd6;

  localparam logic KIND_OBSERVE = 1'b0;
  localparam logic KIND_SETTLE  = 1'b1;

  localparam logic [1:0] REG_SESSION = 2'd0;
  localparam logic [1:0] REG_EPOCH   = 2'd1;
  localparam logic [1:0] REG_MAX_GAP = 2'd2;

  localparam logic [MAXGAP_W-1:0] MAX_GAP_RESET = 7'd64;

  typedef struct packed {
    logic [ID_W-1:0]   session;
    logic [ID_W-1:0]   epoch;
    logic [DIST_W-1:0] gap;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic scan;
  } cmd_t;

  typedef struct packed {
    logic settle_go;
    logic scan_hit;
  } sts_t;

endpackage

// File: hdl/sequence_receive_window.sv
// An item is captured at the accepting edge and classified in the exec state; the result of
// an observe item, or of a settle of an old or unobserved sequence, is registered from there.
// Other settles run the settle scan, checking one slot per cycle; start is taken only when idle.
// The receiver cannot stall. Reset (rst_ni low, async) idles the control and clears the ack
// counter, both bitmaps and the session and epoch registers; the max gap register resets to 64.
// Top level: sequence receive window with configuration port.
module sequence_receive_window (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swr_pkg::ADDR_W-1:0]    paddr,
  input  logic [swr_pkg::DATA_W-1:0]    pwdata,
  output logic [swr_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind_i,
  input  logic                          has_session_i,
  input  logic [swr_pkg::ID_W-1:0]      msg_session_i,
  input  logic [swr_pkg::ID_W-1:0]      msg_epoch_i,
  input  logic [swr_pkg::SEQ_W-1:0]     sequence_number_i,
  output logic                          done_o,
  output logic [swr_pkg::STATUS_W-1:0]  status_o,
  output logic [swr_pkg::SEQ_W-1:0]     acked_through_o
);

  swr_pkg::cfg_t cfg;
  swr_pkg::cmd_t cmd;
  swr_pkg::sts_t sts;

  swr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  swr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  swr_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cfg_i             (cfg),
    .kind_i            (kind_i),
    .has_session_i     (has_session_i),
    .msg_session_i     (msg_session_i),
    .msg_epoch_i       (msg_epoch_i),
    .sequence_number_i (sequence_number_i),
    .sts_o             (sts),
    .done_o            (done_o),
    .status_o          (status_o),
    .acked_through_o   (acked_through_o)
  );

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");

  a_observe_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (kind_i == swr_pkg::KIND_OBSERVE)) |-> ##2 done_o)
    else $error("observe result not delivered after two cycles");

  a_scan_no_cmd_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd.capture, cmd.exec, cmd.scan}) <= 1)
    else $error("controller issued overlapping commands");
`endif

endmodule

// File: hdl/swr_cfg.sv
// Configuration registers behind the APB-style port.
module swr_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [swr_pkg::ADDR_W-1:0]  paddr,
  input  logic [swr_pkg::DATA_W-1:0]  pwdata,
  output logic [swr_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output swr_pkg::cfg_t               cfg_o
);

  logic [swr_pkg::ID_W-1:0]     session_q, session_d;
  logic [swr_pkg::ID_W-1:0]     epoch_q, epoch_d;
  logic [swr_pkg::MAXGAP_W-1:0] max_gap_q, max_gap_d;
  logic [1:0]                   reg_idx;
  logic                         wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    session_d = session_q;
    epoch_d   = epoch_q;
    max_gap_d = max_gap_q;
    if (wr_en) begin
      unique case (reg_idx)
        swr_pkg::REG_SESSION: session_d = pwdata;
        swr_pkg::REG_EPOCH:   epoch_d   = pwdata;
        swr_pkg::REG_MAX_GAP: max_gap_d = pwdata[swr_pkg::MAXGAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      session_q <= '0;
      epoch_q   <= '0;
      max_gap_q <= swr_pkg::MAX_GAP_RESET;
    end else begin
      session_q <= session_d;
      epoch_q   <= epoch_d;
      max_gap_q <= max_gap_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      swr_pkg::REG_SESSION: prdata = session_q;
      swr_pkg::REG_EPOCH:   prdata = epoch_q;
      swr_pkg::REG_MAX_GAP: prdata = {{(swr_pkg::DATA_W-swr_pkg::MAXGAP_W){1'b0}}, max_gap_q};
      default:              prdata = '0;
    endcase
  end

  // gap limit saturates at the window size
  always_comb begin
    cfg_o.session = session_q;
    cfg_o.epoch   = epoch_q;
    if (max_gap_q > swr_pkg::MAXGAP_W'(swr_pkg::WINDOW)) begin
      cfg_o.gap = swr_pkg::DIST_W'(swr_pkg::WINDOW);
    end else begin
      cfg_o.gap = swr_pkg::DIST_W'(max_gap_q);
    end
  end

endmodule

// File: hdl/swr_ctrl.sv
// Controller state machine: capture, classify and settle scan sequencing.
module swr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  swr_pkg::sts_t sts_i,
  output swr_pkg::cmd_t cmd_o,
  output logic          busy_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_SCAN = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.settle_go ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (!sts_i.scan_hit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// File: hdl/swr_dp.sv
// Datapath: item capture, window classification, bitmaps and ack counter.
module swr_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  swr_pkg::cmd_t                 cmd_i,
  input  swr_pkg::cfg_t                 cfg_i,
  input  logic                          kind_i,
  input  logic                          has_session_i,
  input  logic [swr_pkg::ID_W-1:0]      msg_session_i,
  input  logic [swr_pkg::ID_W-1:0]      msg_epoch_i,
  input  logic [swr_pkg::SEQ_W-1:0]     sequence_number_i,
  output swr_pkg::sts_t                 sts_o,
  output logic                          done_o,
  output logic [swr_pkg::STATUS_W-1:0]  status_o,
  output logic [swr_pkg::SEQ_W-1:0]     acked_through_o
);

  logic [swr_pkg::SEQ_W-1:0]    ack_q, ack_d;
  logic [swr_pkg::SLOT_W-1:0]   ptr_q, ptr_d;
  logic [swr_pkg::WINDOW-1:0]   obs_q, obs_d;
  logic [swr_pkg::WINDOW-1:0]   set_q, set_d;

  logic                         kind_q, stale_q, malformed_q, le_q, dbig_q;
  logic [swr_pkg::DIST_W-1:0]   dlow_q;
  logic [swr_pkg::SLOT_W-1:0]   slot_q;

  logic                         res_valid_q, res_valid_d;
  logic [swr_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  logic [swr_pkg::SEQ_W-1:0]    res_ack_q, res_ack_d;

  logic [swr_pkg::SEQ_W:0]      diff;
  logic                         far, seen, over_gap, scan_hit;

  // borrow of the subtraction flags seq < ack
  assign diff = {1'b0, sequence_number_i} - {1'b0, ack_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q      <= kind_i;
      stale_q     <= !has_session_i || (msg_session_i != cfg_i.session);
      malformed_q <= (msg_epoch_i != cfg_i.epoch) || (sequence_number_i == '0);
      le_q        <= diff[swr_pkg::SEQ_W] || (diff[swr_pkg::SEQ_W-1:0] == '0);
      dbig_q      <= |diff[swr_pkg::SEQ_W-1:swr_pkg::DIST_W];
      dlow_q      <= diff[swr_pkg::DIST_W-1:0];
      slot_q      <= sequence_number_i[swr_pkg::SLOT_W-1:0];
    end
  end

  assign far      = dbig_q || (dlow_q > swr_pkg::DIST_W'(swr_pkg::WINDOW));
  assign seen     = !le_q && !far && obs_q[slot_q];
  assign over_gap = dbig_q || (dlow_q > cfg_i.gap);
  assign scan_hit = set_q[ptr_q];

  assign sts_o.settle_go = cmd_i.exec && (kind_q == swr_pkg::KIND_SETTLE) && !le_q && seen;
  assign sts_o.scan_hit  = scan_hit;

  always_comb begin
    ack_d        = ack_q;
    ptr_d        = ptr_q;
    obs_d        = obs_q;
    set_d        = set_q;
    res_valid_d  = 1'b0;
    res_status_d = res_status_q;
    res_ack_d    = res_ack_q;
    if (cmd_i.exec) begin
      res_ack_d = ack_q;
      if (kind_q == swr_pkg::KIND_OBSERVE) begin
        res_valid_d = 1'b1;
        priority if (stale_q) begin
          res_status_d = swr_pkg::ST_STALE;
        end else if (malformed_q) begin
          res_status_d = swr_pkg::ST_MALFORMED;
        end else if (le_q || seen) begin
          res_status_d = swr_pkg::ST_DUPLICATE;
        end else if (over_gap) begin
          res_status_d = swr_pkg::ST_GAP;
        end else begin
          obs_d[slot_q] = 1'b1;
          res_status_d  = (dlow_q == swr_pkg::DIST_W'(1)) ?
                          swr_pkg::ST_IN_ORDER : swr_pkg::ST_OUT_OF_ORDER;
        end
      end else begin
        priority if (le_q) begin
          res_valid_d  = 1'b1;
          res_status_d = swr_pkg::ST_SETTLED;
        end else if (!seen) begin
          res_valid_d  = 1'b1;
          res_status_d = swr_pkg::ST_GAP;
        end else begin
          set_d[slot_q] = 1'b1;
        end
      end
    end else if (cmd_i.scan) begin
      if (scan_hit) begin
        set_d[ptr_q] = 1'b0;
        obs_d[ptr_q] = 1'b0;
        ack_d        = ack_q + swr_pkg::SEQ_W'(1);
        ptr_d        = (ptr_q == swr_pkg::SLOT_W'(swr_pkg::WINDOW - 1)) ?
                       '0 : ptr_q + swr_pkg::SLOT_W'(1);
      end else begin
        res_valid_d  = 1'b1;
        res_status_d = swr_pkg::ST_SETTLED;
        res_ack_d    = ack_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_q       <= '0;
      ptr_q       <= swr_pkg::SLOT_W'(1);
      obs_q       <= '0;
      set_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      ack_q       <= ack_d;
      ptr_q       <= ptr_d;
      obs_q       <= obs_d;
      set_q       <= set_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_ack_q    <= res_ack_d;
  end

  assign done_o          = res_valid_q;
  assign status_o        = res_status_q;
  assign acked_through_o = res_ack_q;

endmodule
